### sv/hec_pkg.sv
`timescale 1ns / 1ps

package hec_pkg;

   localparam int MAX_HE     = 16;
   localparam int MIN_HE     = 3;
   localparam int IDX_W      = $clog2(MAX_HE);
   localparam int CNT_W      = $clog2(MAX_HE + 1);
   localparam int FACE_W     = 16;
   localparam int REC_W      = 6 + 2 * FACE_W;
   localparam int REQ_DATA_W = ((REC_W + 7) / 8) * 8;
   localparam int RSP_W      = IDX_W + 3;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

   // Packed so that the lowest bit of tdata lands in has_edge.
   typedef struct packed {
      logic              slot1_right;
      logic [FACE_W-1:0] slot1_face;
      logic              slot1_valid;
      logic              slot0_right;
      logic [FACE_W-1:0] slot0_face;
      logic              slot0_valid;
      logic              at_start;
      logic              has_edge;
   } hec_rec_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TOO_FEW      = 3'd1,
      ST_CLOSED_EARLY = 3'd2,
      ST_NO_RIGHT     = 3'd3,
      ST_NO_NEXT      = 3'd4,
      ST_MULTI_NEXT   = 3'd5,
      ST_NOT_CLOSED   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_START,
      S_STEP,
      S_RIGHT,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DECIDE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       mark;
      logic       take_face;
      logic       scan_rd;
      logic       scan_ev;
      logic       advance;
      logic       set_status;
      status_type status;
      logic       emit;
      logic       clear;
   } hec_cmd_type;

   typedef struct packed {
      logic count_lt3;
      logic step_done;
      logic cur_visited;
      logic cur_zero;
      logic right_ok;
      logic scan_done;
      logic found_zero;
      logic found_multi;
      logic out_last;
      logic out_free;
   } hec_sts_type;

endpackage

### sv/hec_ctrl.sv
`timescale 1ns / 1ps

module hec_ctrl
   import hec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   input  hec_sts_type sts,
   output hec_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid && req_tlast) state_in = S_START;
         end
         S_START: begin
            state_in = sts.count_lt3 ? S_EMIT : S_STEP;
         end
         S_STEP: begin
            state_in = (sts.step_done || sts.cur_visited) ? S_EMIT : S_RIGHT;
         end
         S_RIGHT: begin
            state_in = sts.right_ok ? S_SCAN_RD : S_EMIT;
         end
         S_SCAN_RD: begin
            state_in = sts.scan_done ? S_DECIDE : S_SCAN_EV;
         end
         S_SCAN_EV: begin
            state_in = S_SCAN_RD;
         end
         S_DECIDE: begin
            state_in = (sts.found_zero || sts.found_multi) ? S_EMIT : S_STEP;
         end
         S_EMIT: begin
            if (sts.out_free && sts.out_last) state_in = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      req_tready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_START: begin
            cmd.start = 1'b1;
            if (sts.count_lt3) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_TOO_FEW;
            end
         end
         S_STEP: begin
            if (sts.step_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = sts.cur_zero ? ST_OK : ST_NOT_CLOSED;
            end else if (sts.cur_visited) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_CLOSED_EARLY;
            end else begin
               cmd.mark = 1'b1;
            end
         end
         S_RIGHT: begin
            if (sts.right_ok) begin
               cmd.take_face = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_RIGHT;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = !sts.scan_done;
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
         end
         S_DECIDE: begin
            if (sts.found_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_NEXT;
            end else if (sts.found_multi) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_MULTI_NEXT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_EMIT: begin
            cmd.emit  = sts.out_free;
            cmd.clear = sts.out_free && sts.out_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/hec_datapath.sv
`timescale 1ns / 1ps

module hec_datapath
   import hec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  hec_cmd_type           cmd,
   output hec_sts_type           sts
);

   // A slot decides the side of a face only if it is the first slot holding it.
   function automatic logic left_of(hec_rec_type r, logic [FACE_W-1:0] f);
      logic hit0;
      logic hit1;
      hit0 = r.slot0_valid && (r.slot0_face == f);
      hit1 = r.slot1_valid && (r.slot1_face == f);
      if (!r.has_edge) return 1'b0;
      if (hit0) return r.slot0_right != r.at_start;
      return hit1 && (r.slot1_right != r.at_start);
   endfunction

   hec_rec_type            rec_mem [MAX_HE];
   hec_rec_type            rd_rec_ff;
   logic [IDX_W-1:0]       order_ff [MAX_HE];

   logic [CNT_W-1:0]       count_ff,   count_in;
   logic [IDX_W-1:0]       cur_ff,     cur_in;
   logic [IDX_W-1:0]       next_ff,    next_in;
   logic [CNT_W-1:0]       step_ff,    step_in;
   logic [CNT_W-1:0]       scan_ff,    scan_in;
   logic [1:0]             found_ff,   found_in;
   logic [MAX_HE-1:0]      visited_ff, visited_in;
   logic [FACE_W-1:0]      face_ff,    face_in;
   status_type             status_ff,  status_in;
   logic [IDX_W-1:0]       out_idx_ff, out_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic                   rsp_last_ff,  rsp_last_in;

   hec_rec_type            req_rec;
   logic [IDX_W-1:0]       rd_addr;
   logic                   rd_en;
   logic                   right_ok;
   logic [FACE_W-1:0]      right_face;
   logic                   left_hit;
   logic [IDX_W-1:0]       out_src;
   logic                   out_last;

   assign req_rec = hec_rec_type'(req_tdata[REC_W-1:0]);
   assign rd_en   = cmd.mark || cmd.scan_rd;
   assign rd_addr = cmd.mark ? cur_ff : scan_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CNT_W'(MAX_HE))) begin
         rec_mem[count_ff[IDX_W-1:0]] <= req_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= rec_mem[rd_addr];
      end
      if (cmd.mark) begin
         order_ff[step_ff[IDX_W-1:0]] <= cur_ff;
      end
   end

   // Right face of the current half-edge. Slot 1 only counts when slot 0 does
   // not already hold the same face.
   always_comb begin
      right_ok   = 1'b0;
      right_face = rd_rec_ff.slot0_face;
      if (rd_rec_ff.has_edge) begin
         if (rd_rec_ff.slot0_valid && (rd_rec_ff.slot0_right == rd_rec_ff.at_start)) begin
            right_ok = 1'b1;
         end else if (rd_rec_ff.slot1_valid &&
                      !(rd_rec_ff.slot0_valid &&
                        (rd_rec_ff.slot0_face == rd_rec_ff.slot1_face)) &&
                      (rd_rec_ff.slot1_right == rd_rec_ff.at_start)) begin
            right_ok   = 1'b1;
            right_face = rd_rec_ff.slot1_face;
         end
      end
   end

   assign left_hit = left_of(rd_rec_ff, face_ff) && (scan_ff != {1'b0, cur_ff});
   assign out_last = ((CNT_W'(out_idx_ff) + CNT_W'(1)) == count_ff);
   assign out_src  = (status_ff == ST_OK) ? order_ff[out_idx_ff] : out_idx_ff;

   always_comb begin
      count_in     = count_ff;
      cur_in       = cur_ff;
      next_in      = next_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      visited_in   = visited_ff;
      face_in      = face_ff;
      status_in    = status_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load && (count_ff < CNT_W'(MAX_HE))) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         cur_in     = '0;
         step_in    = '0;
         visited_in = '0;
         out_idx_in = '0;
      end
      if (cmd.mark) begin
         visited_in[cur_ff] = 1'b1;
      end
      if (cmd.take_face) begin
         face_in  = right_face;
         scan_in  = '0;
         found_in = 2'd0;
      end
      if (cmd.scan_ev) begin
         scan_in = scan_ff + CNT_W'(1);
         if (left_hit) begin
            if (found_ff == 2'd0) begin
               next_in  = scan_ff[IDX_W-1:0];
               found_in = 2'd1;
            end else begin
               found_in = 2'd2;
            end
         end
      end
      if (cmd.advance) begin
         cur_in  = next_ff;
         step_in = step_ff + CNT_W'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({status_ff, out_src});
         rsp_last_in  = out_last;
         out_idx_in   = out_idx_ff + IDX_W'(1);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         visited_ff   <= '0;
         found_ff     <= 2'd0;
         scan_ff      <= '0;
         step_ff      <= '0;
         cur_ff       <= '0;
         out_idx_ff   <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         visited_ff   <= visited_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
         step_ff      <= step_in;
         cur_ff       <= cur_in;
         out_idx_ff   <= out_idx_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      next_ff     <= next_in;
      face_ff     <= face_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign sts.count_lt3   = count_ff < CNT_W'(MIN_HE);
   assign sts.step_done   = step_ff == count_ff;
   assign sts.cur_visited = visited_ff[cur_ff];
   assign sts.cur_zero    = cur_ff == '0;
   assign sts.right_ok    = right_ok;
   assign sts.scan_done   = scan_ff == count_ff;
   assign sts.found_zero  = found_ff == 2'd0;
   assign sts.found_multi = found_ff == 2'd2;
   assign sts.out_last    = out_last;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/half_edge_cycle_order_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Item                          Handshake
// req_*     in         one half-edge record          tvalid/tready, tlast ends the vertex
// rsp_*     out        one source index with status  tvalid/tready, tlast ends the order
//
// On the closing record the walk starts; each walk step, for n stored
// half-edges, does one record memory read for the current half-edge, then
// a scan of all n records through the same read port. Results then leave at
// one per cycle from the output register while the receiver takes them.
// Reset is synchronous and clears the record count and the controller.
// A stalled result holds in the output register; records are not taken until
// the last result of the vertex has been loaded into it.

module half_edge_cycle_order_unit
   import hec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata, low bit up: has_edge, at_start, slot0_valid, slot0_face[16],
   // slot0_right, slot1_valid, slot1_face[16], slot1_right, zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // rsp_tdata, low bit up: source_index[4], status[3], zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   hec_cmd_type cmd;
   hec_sts_type sts;

   hec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hec_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Records are never taken while results are being loaded.
   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && cmd.emit))
      else $error("record accepted while emitting results");

   // Loading the last result returns the block to taking records.
   a_clear_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> req_tready)
      else $error("block did not reopen after the last result");

   // Once a status is decided the walk does not take another step.
   a_status_ends_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.set_status |=> !cmd.mark && !cmd.advance)
      else $error("walk continued after its status was set");

   // A result is only loaded into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a waiting result");

endmodule
